// ----- hw/rtl/paeg_pkg.sv -----
// Shared constants for the preferential attachment edge generator.
// Holds field widths, store depths, register indexes and scenario codes.
// No dependencies; used by the top level and its port checker.
package paeg_pkg;

  localparam int MAX_EDGES  = 65536;
  localparam int NODE_DEPTH = 2 * MAX_EDGES;
  localparam int DRAW_SCALE = 100000;
  localparam int Q_ONE_BITS = 16;

  localparam int EW = $clog2(MAX_EDGES);   // edge store address
  localparam int NW = $clog2(NODE_DEPTH);  // node store address
  localparam int VW = 17;                  // node ids, degrees, draws
  localparam int CW = 17;                  // edge count
  localparam int NCW = 18;                 // node count
  localparam int DQW = 24;                 // Q8.16 delta
  localparam int PW = 17;                  // probability registers

  // pick datapath widths
  localparam int NDW  = NCW + DQW;         // n * delta
  localparam int WW   = NDW + 1;           // total weight
  localparam int SW   = VW + WW;           // scaled draw
  localparam int DVW  = 41;                // divisor
  localparam int QW   = 19;                // quotient bits
  localparam int EPW  = CW + 33;           // e * scale * 2^16
  localparam int KW   = QW + 1;

  localparam logic [DVW-1:0] EDGE_DIV = DVW'(64'(DRAW_SCALE) << Q_ONE_BITS);
  localparam logic [32:0]    EDGE_SCALE = 33'(64'(DRAW_SCALE) << Q_ONE_BITS);

  // configuration register indexes
  localparam logic [2:0] REG_ALPHA  = 3'd0;
  localparam logic [2:0] REG_BETA   = 3'd1;
  localparam logic [2:0] REG_GAMMA  = 3'd2;
  localparam logic [2:0] REG_XI     = 3'd3;
  localparam logic [2:0] REG_DIN    = 3'd4;
  localparam logic [2:0] REG_DOUT   = 3'd5;
  localparam logic [2:0] REG_TARGET = 3'd6;

  // scenario codes
  localparam logic [2:0] SCEN_NONE  = 3'd0;
  localparam logic [2:0] SCEN_ALPHA = 3'd1;
  localparam logic [2:0] SCEN_BETA  = 3'd2;
  localparam logic [2:0] SCEN_GAMMA = 3'd3;
  localparam logic [2:0] SCEN_XI    = 3'd4;
  localparam logic [2:0] SCEN_LOOP  = 3'd5;

endpackage

// ----- hw/rtl/preferential_attachment_edge_generator.sv -----
// Preferential attachment edge generator: edge and degree stores with a
// multiply/divide pick sequencer. Depends on paeg_pkg.
//
// channel   direction  handshake              payload
// request   in         start & !busy          mode, u_draw, v_draw, w_draw, node_index
// result    out        done (one cycle)       edge_from .. finished
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// A degree read passes through S_DEG_RD and S_DEG_OUT; a read of a missing node or a step
// after the target is answered straight from idle. An endpoint pick runs four multiply stages,
// a sum, a compare, a setup step, a 19-step restoring divider and a finish step, and
// also S_ERD and S_EGET when it reads the edge store. Store updates and the answer follow:
// S_NEW0 and S_EMIT for a self-loop, with S_NEW1 between for a pair; a pick (twice for beta)
// goes through S_RMW_RD and S_RMW_WR first. Reset is synchronous; S_INIT0 and S_INIT1 then
// seed the stores, with busy high. The receiver cannot stall; cfg_ready is always high.
module preferential_attachment_edge_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [16:0] u_draw,
  input  logic [16:0] v_draw,
  input  logic [16:0] w_draw,
  input  logic [16:0] node_index,
  output logic        done,
  output logic [16:0] edge_from,
  output logic [16:0] edge_to,
  output logic [2:0]  scenario,
  output logic [16:0] edge_count,
  output logic [17:0] node_count,
  output logic [16:0] in_degree,
  output logic [16:0] out_degree,
  output logic        finished,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam logic [4:0] S_INIT0   = 5'd0;
  localparam logic [4:0] S_INIT1   = 5'd1;
  localparam logic [4:0] S_IDLE    = 5'd2;
  localparam logic [4:0] S_DEG_RD  = 5'd3;
  localparam logic [4:0] S_DEG_OUT = 5'd4;
  localparam logic [4:0] S_MUL1    = 5'd5;
  localparam logic [4:0] S_MUL2    = 5'd6;
  localparam logic [4:0] S_MUL3    = 5'd7;
  localparam logic [4:0] S_MUL4    = 5'd8;
  localparam logic [4:0] S_SUM     = 5'd9;
  localparam logic [4:0] S_CMP     = 5'd10;
  localparam logic [4:0] S_OVF     = 5'd11;
  localparam logic [4:0] S_DIV     = 5'd12;
  localparam logic [4:0] S_FIN     = 5'd13;
  localparam logic [4:0] S_ERD     = 5'd14;
  localparam logic [4:0] S_EGET    = 5'd15;
  localparam logic [4:0] S_RMW_RD  = 5'd16;
  localparam logic [4:0] S_RMW_WR  = 5'd17;
  localparam logic [4:0] S_NEW0    = 5'd18;
  localparam logic [4:0] S_NEW1    = 5'd19;
  localparam logic [4:0] S_EMIT    = 5'd20;

  localparam int VW  = paeg_pkg::VW;
  localparam int EW  = paeg_pkg::EW;
  localparam int NW  = paeg_pkg::NW;
  localparam int CW  = paeg_pkg::CW;
  localparam int NCW = paeg_pkg::NCW;
  localparam int DQW = paeg_pkg::DQW;
  localparam int PW  = paeg_pkg::PW;
  localparam int NDW = paeg_pkg::NDW;
  localparam int WW  = paeg_pkg::WW;
  localparam int SW  = paeg_pkg::SW;
  localparam int DVW = paeg_pkg::DVW;
  localparam int QW  = paeg_pkg::QW;
  localparam int EPW = paeg_pkg::EPW;
  localparam int KW  = paeg_pkg::KW;
  localparam int HW  = WW - DQW;

  // stores
  logic [VW-1:0] src_mem [paeg_pkg::MAX_EDGES];
  logic [VW-1:0] tgt_mem [paeg_pkg::MAX_EDGES];
  logic [VW-1:0] in_mem  [paeg_pkg::NODE_DEPTH];
  logic [VW-1:0] out_mem [paeg_pkg::NODE_DEPTH];

  logic [4:0]     state;
  logic [PW-1:0]  alpha_units, beta_units, gamma_units, xi_units;
  logic [DQW-1:0] delta_in_q, delta_out_q;
  logic [CW-1:0]  target_edges;
  logic [CW-1:0]  e_cnt;
  logic [NCW-1:0] n_cnt;

  logic [VW-1:0]  v_q, w_q, node_q, from_q, to_q;
  logic [2:0]     scen_q;
  logic           psel;

  logic [NDW-1:0] nd;
  logic [DVW-1:0] div_dq;
  logic [WW-1:0]  w_sum;
  logic [EPW-1:0] edge_part;
  logic [40:0]    pp_lo;
  logic [VW+HW-1:0] pp_hi;
  logic [SW-1:0]  scaled;
  logic [SW-1:0]  dividend;
  logic [DVW-1:0] divisor;
  logic           is_edge, ovf;
  logic [DVW-1:0] rem;
  logic [QW-1:0]  dlo, quo;
  logic [4:0]     cnt;
  logic [EW-1:0]  pidx;

  logic [VW-1:0]  src_rd, tgt_rd, in_rd, out_rd;

  // write and read ports
  logic           edge_we, in_we, out_we;
  logic [EW-1:0]  edge_waddr;
  logic [VW-1:0]  src_wdata, tgt_wdata;
  logic [NW-1:0]  in_waddr, out_waddr, in_raddr, out_raddr;
  logic [VW-1:0]  in_wdata, out_wdata;

  logic [CW-1:0]  eff_target;
  logic           gen_done;
  logic [PW:0]    t2;
  logic [PW+1:0]  t3, t4;
  logic [2:0]     scen_pick;
  logic [VW-1:0]  draw;
  logic [DQW-1:0] dq_raw, dq_eff;
  logic [DVW:0]   trial, trial_diff;
  logic           trial_ge;
  logic [KW-1:0]  k_val, idx_val;
  logic [EW-1:0]  edge_idx;
  logic [VW-1:0]  node_pick;
  logic [NW-1:0]  n_addr, n1_addr;
  logic           new_in, new_out;
  logic [1:0]     n_add;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  assign eff_target = (target_edges < CW'(paeg_pkg::MAX_EDGES)) ? target_edges
                                                                 : CW'(paeg_pkg::MAX_EDGES);
  assign gen_done = (e_cnt >= eff_target);

  assign t2 = {1'b0, alpha_units} + {1'b0, beta_units};
  assign t3 = {1'b0, t2} + (PW+2)'(gamma_units);
  assign t4 = t3 + (PW+2)'(xi_units);

  always_comb begin
    if ((PW+2)'(u_draw) <= (PW+2)'(alpha_units)) begin
      scen_pick = paeg_pkg::SCEN_ALPHA;
    end else if ((PW+2)'(u_draw) <= (PW+2)'(t2)) begin
      scen_pick = paeg_pkg::SCEN_BETA;
    end else if ((PW+2)'(u_draw) <= t3) begin
      scen_pick = paeg_pkg::SCEN_GAMMA;
    end else if ((PW+2)'(u_draw) <= t4) begin
      scen_pick = paeg_pkg::SCEN_XI;
    end else begin
      scen_pick = paeg_pkg::SCEN_LOOP;
    end
  end

  assign draw   = psel ? w_q : v_q;
  assign dq_raw = psel ? delta_out_q : delta_in_q;
  assign dq_eff = (dq_raw == '0) ? DQW'(1) : dq_raw;

  assign trial      = {rem, dlo[QW-1]};
  assign trial_ge   = (trial >= {1'b0, divisor});
  assign trial_diff = trial - {1'b0, divisor};

  // ceil quotient minus one, clamped at zero and at the top of the range
  assign k_val   = KW'(quo) + KW'(rem != '0);
  assign idx_val = (k_val == '0) ? '0 : k_val - KW'(1);
  assign edge_idx = (idx_val >= KW'(e_cnt)) ? EW'(e_cnt - CW'(1)) : EW'(idx_val);
  assign node_pick = (ovf || idx_val >= KW'(n_cnt)) ? VW'(n_cnt - NCW'(1)) : VW'(idx_val);

  assign n_addr  = NW'(n_cnt);
  assign n1_addr = NW'(n_cnt + NCW'(1));
  assign new_in  = (scen_q == paeg_pkg::SCEN_GAMMA) || (scen_q == paeg_pkg::SCEN_LOOP);
  assign new_out = (scen_q == paeg_pkg::SCEN_ALPHA) || (scen_q == paeg_pkg::SCEN_XI) ||
                   (scen_q == paeg_pkg::SCEN_LOOP);

  always_comb begin
    case (scen_q)
      paeg_pkg::SCEN_BETA: n_add = 2'd0;
      paeg_pkg::SCEN_XI:   n_add = 2'd2;
      default:             n_add = 2'd1;
    endcase
  end

  assign in_raddr  = (state == S_DEG_RD) ? NW'(node_q) : NW'(to_q);
  assign out_raddr = (state == S_DEG_RD) ? NW'(node_q) : NW'(from_q);

  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = EW'(e_cnt);
    src_wdata  = from_q;
    tgt_wdata  = to_q;
    in_we      = 1'b0;
    in_waddr   = n_addr;
    in_wdata   = '0;
    out_we     = 1'b0;
    out_waddr  = n_addr;
    out_wdata  = '0;
    case (state)
      S_INIT0: begin
        edge_we    = 1'b1;
        edge_waddr = '0;
        src_wdata  = VW'(0);
        tgt_wdata  = VW'(1);
        in_we      = 1'b1;
        in_waddr   = '0;
        in_wdata   = VW'(0);
        out_we     = 1'b1;
        out_waddr  = '0;
        out_wdata  = VW'(1);
      end
      S_INIT1: begin
        in_we     = 1'b1;
        in_waddr  = NW'(1);
        in_wdata  = VW'(1);
        out_we    = 1'b1;
        out_waddr = NW'(1);
        out_wdata = VW'(0);
      end
      S_RMW_WR: begin
        in_we     = (scen_q == paeg_pkg::SCEN_ALPHA) || (scen_q == paeg_pkg::SCEN_BETA);
        in_waddr  = NW'(to_q);
        in_wdata  = in_rd + VW'(1);
        out_we    = (scen_q == paeg_pkg::SCEN_BETA) || (scen_q == paeg_pkg::SCEN_GAMMA);
        out_waddr = NW'(from_q);
        out_wdata = out_rd + VW'(1);
      end
      S_NEW0: begin
        edge_we   = 1'b1;
        in_we     = (scen_q != paeg_pkg::SCEN_BETA);
        in_wdata  = VW'(new_in);
        out_we    = (scen_q != paeg_pkg::SCEN_BETA);
        out_wdata = VW'(new_out);
      end
      S_NEW1: begin
        in_we     = 1'b1;
        in_waddr  = n1_addr;
        in_wdata  = VW'(1);
        out_we    = 1'b1;
        out_waddr = n1_addr;
        out_wdata = VW'(0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      src_mem[edge_waddr] <= src_wdata;
      tgt_mem[edge_waddr] <= tgt_wdata;
    end
    src_rd <= src_mem[pidx];
    tgt_rd <= tgt_mem[pidx];
  end

  always_ff @(posedge clk) begin
    if (in_we) begin
      in_mem[in_waddr] <= in_wdata;
    end
    in_rd <= in_mem[in_raddr];
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[out_waddr] <= out_wdata;
    end
    out_rd <= out_mem[out_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_units  <= PW'(30000);
      beta_units   <= PW'(40000);
      gamma_units  <= PW'(30000);
      xi_units     <= PW'(0);
      delta_in_q   <= DQW'(65536);
      delta_out_q  <= DQW'(65536);
      target_edges <= CW'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        paeg_pkg::REG_ALPHA:  alpha_units  <= cfg_data[PW-1:0];
        paeg_pkg::REG_BETA:   beta_units   <= cfg_data[PW-1:0];
        paeg_pkg::REG_GAMMA:  gamma_units  <= cfg_data[PW-1:0];
        paeg_pkg::REG_XI:     xi_units     <= cfg_data[PW-1:0];
        paeg_pkg::REG_DIN:    delta_in_q   <= cfg_data;
        paeg_pkg::REG_DOUT:   delta_out_q  <= cfg_data;
        paeg_pkg::REG_TARGET: target_edges <= cfg_data[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and pick datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
      e_cnt <= CW'(1);
      n_cnt <= NCW'(2);
      done  <= 1'b0;
    end else begin
      // strobe on the answering states and on a request answered at once
      done <= (state == S_DEG_OUT) || (state == S_EMIT) ||
              ((state == S_IDLE) && start &&
               (mode ? (NCW'(node_index) >= n_cnt) : gen_done));
      case (state)
        S_INIT0: state <= S_INIT1;
        S_INIT1: state <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            v_q    <= v_draw;
            w_q    <= w_draw;
            node_q <= node_index;
            scen_q <= scen_pick;
            from_q <= VW'(n_cnt);
            to_q   <= (scen_pick == paeg_pkg::SCEN_XI) ? VW'(n_cnt + NCW'(1)) : VW'(n_cnt);
            psel   <= (scen_pick == paeg_pkg::SCEN_GAMMA);
            if ((mode && NCW'(node_index) < n_cnt)) begin
              state <= S_DEG_RD;
            end else if (mode || gen_done) begin
              // answer at once: nothing to look up or add
              edge_from  <= '0;
              edge_to    <= '0;
              scenario   <= paeg_pkg::SCEN_NONE;
              edge_count <= e_cnt;
              node_count <= n_cnt;
              in_degree  <= '0;
              out_degree <= '0;
              finished   <= gen_done;
            end else if (scen_pick == paeg_pkg::SCEN_XI ||
                         scen_pick == paeg_pkg::SCEN_LOOP) begin
              state <= S_NEW0;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_DEG_RD: state <= S_DEG_OUT;
        S_DEG_OUT: begin
          edge_from  <= '0;
          edge_to    <= '0;
          scenario   <= paeg_pkg::SCEN_NONE;
          edge_count <= e_cnt;
          node_count <= n_cnt;
          in_degree  <= in_rd;
          out_degree <= out_rd;
          finished   <= gen_done;
          state      <= S_IDLE;
        end
        S_MUL1: begin
          nd     <= NDW'(n_cnt) * NDW'(dq_eff);
          div_dq <= DVW'(dq_eff) * DVW'(paeg_pkg::DRAW_SCALE);
          state  <= S_MUL2;
        end
        S_MUL2: begin
          w_sum     <= WW'({e_cnt, 16'b0}) + WW'(nd);
          edge_part <= EPW'(e_cnt) * EPW'(paeg_pkg::EDGE_SCALE);
          state     <= S_MUL3;
        end
        S_MUL3: begin
          pp_lo <= 41'(draw) * 41'(w_sum[DQW-1:0]);
          state <= S_MUL4;
        end
        S_MUL4: begin
          pp_hi <= (VW+HW)'(draw) * (VW+HW)'(w_sum[WW-1:DQW]);
          state <= S_SUM;
        end
        S_SUM: begin
          scaled <= SW'(pp_lo) + {pp_hi, {DQW{1'b0}}};
          state  <= S_CMP;
        end
        S_CMP: begin
          if (scaled < SW'(edge_part)) begin
            is_edge  <= 1'b1;
            dividend <= scaled;
            divisor  <= paeg_pkg::EDGE_DIV;
          end else begin
            is_edge  <= 1'b0;
            dividend <= scaled - SW'(edge_part);
            divisor  <= div_dq;
          end
          state <= S_OVF;
        end
        S_OVF: begin
          // quotient too wide for the divider: it clamps anyway
          ovf   <= (dividend >= {divisor, {QW{1'b0}}});
          rem   <= dividend[SW-1:QW];
          dlo   <= dividend[QW-1:0];
          quo   <= '0;
          cnt   <= 5'(QW - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (trial_ge) begin
            rem <= trial_diff[DVW-1:0];
          end else begin
            rem <= trial[DVW-1:0];
          end
          quo <= {quo[QW-2:0], trial_ge};
          dlo <= {dlo[QW-2:0], 1'b0};
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_FIN: begin
          if (is_edge && !ovf) begin
            pidx  <= edge_idx;
            state <= S_ERD;
          end else begin
            if (psel) begin
              from_q <= node_pick;
            end else begin
              to_q <= node_pick;
            end
            if (!psel && scen_q == paeg_pkg::SCEN_BETA) begin
              psel  <= 1'b1;
              state <= S_MUL1;
            end else begin
              state <= S_RMW_RD;
            end
          end
        end
        S_ERD: state <= S_EGET;
        S_EGET: begin
          if (psel) begin
            from_q <= src_rd;
          end else begin
            to_q <= tgt_rd;
          end
          if (!psel && scen_q == paeg_pkg::SCEN_BETA) begin
            psel  <= 1'b1;
            state <= S_MUL1;
          end else begin
            state <= S_RMW_RD;
          end
        end
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: state <= S_NEW0;
        S_NEW0:   state <= (scen_q == paeg_pkg::SCEN_XI) ? S_NEW1 : S_EMIT;
        S_NEW1:   state <= S_EMIT;
        S_EMIT: begin
          e_cnt      <= e_cnt + CW'(1);
          n_cnt      <= n_cnt + NCW'(n_add);
          edge_from  <= from_q;
          edge_to    <= to_q;
          scenario   <= scen_q;
          edge_count <= e_cnt + CW'(1);
          node_count <= n_cnt + NCW'(n_add);
          in_degree  <= '0;
          out_degree <= '0;
          finished   <= ((e_cnt + CW'(1)) >= eff_target);
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/paeg_checker.sv -----
// Port-level checks for the preferential attachment edge generator.
// Depends on paeg_pkg; bound to the top level below.
module paeg_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [16:0] edge_from,
  input logic [16:0] edge_to,
  input logic [2:0]  scenario,
  input logic [16:0] in_degree,
  input logic [16:0] out_degree
);

  // an accepted request either runs or answers on the next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither started nor answered");

  a_scen_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (scenario <= paeg_pkg::SCEN_LOOP))
    else $error("scenario code out of range");

  a_no_edge_zero: assert property (@(posedge clk) disable iff (rst)
    (done && scenario == paeg_pkg::SCEN_NONE) |-> (edge_from == '0 && edge_to == '0))
    else $error("edge endpoints set without an edge");

  a_edge_no_deg: assert property (@(posedge clk) disable iff (rst)
    (done && scenario != paeg_pkg::SCEN_NONE) |-> (in_degree == '0 && out_degree == '0))
    else $error("degrees reported on an edge result");

  a_loop_same: assert property (@(posedge clk) disable iff (rst)
    (done && scenario == paeg_pkg::SCEN_LOOP) |-> (edge_from == edge_to))
    else $error("self-loop with different endpoints");

endmodule

bind preferential_attachment_edge_generator paeg_checker u_paeg_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .edge_from  (edge_from),
  .edge_to    (edge_to),
  .scenario   (scenario),
  .in_degree  (in_degree),
  .out_degree (out_degree)
);

// ----- tb/sv/tb_preferential_attachment_edge_generator.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the preferential attachment edge generator.
// Predicts every result from a local copy of the graph; depends on paeg_pkg.
module tb_preferential_attachment_edge_generator;

  typedef struct {
    logic [16:0] from_node;
    logic [16:0] to_node;
    logic [2:0]  scen;
    logic [16:0] edges;
    logic [17:0] nodes;
    logic [16:0] indeg;
    logic [16:0] outdeg;
    logic        fin;
  } graph_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = 1'b0;
  logic [16:0] u_draw = '0, v_draw = '0, w_draw = '0, node_index = '0;
  logic        done;
  logic [16:0] edge_from, edge_to, edge_count, in_degree, out_degree;
  logic [2:0]  scenario;
  logic [17:0] node_count;
  logic        finished;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  preferential_attachment_edge_generator dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local graph model
  logic [16:0] p_alpha, p_beta, p_gamma, p_xi, p_target;
  logic [23:0] p_din, p_dout;
  int unsigned num_edges, num_nodes;
  logic [16:0] src_of_edge [paeg_pkg::MAX_EDGES];
  logic [16:0] dst_of_edge [paeg_pkg::MAX_EDGES];
  logic [16:0] in_deg [paeg_pkg::NODE_DEPTH];
  logic [16:0] out_deg [paeg_pkg::NODE_DEPTH];

  graph_result_t pending_results[$];
  int errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int unsigned stop_count();
    return (p_target < paeg_pkg::MAX_EDGES) ? p_target : paeg_pkg::MAX_EDGES;
  endfunction

  function automatic logic [16:0] weighted_pick(input logic [16:0] draw,
                                                input logic [23:0] dq_reg,
                                                input bit by_target);
    longint unsigned e, n, dq, scaled, edge_part, k, idx;
    e = num_edges;
    n = num_nodes;
    dq = (dq_reg == 0) ? 1 : dq_reg;
    scaled = draw * (e * 65536 + n * dq);
    edge_part = e * 65536 * paeg_pkg::DRAW_SCALE;
    if (scaled < edge_part) begin
      k = (scaled + 65536 * paeg_pkg::DRAW_SCALE - 1) / (65536 * paeg_pkg::DRAW_SCALE);
      idx = (k > 0) ? k - 1 : 0;
      if (idx >= e) idx = e - 1;
      return by_target ? dst_of_edge[idx] : src_of_edge[idx];
    end
    k = (scaled - edge_part + paeg_pkg::DRAW_SCALE * dq - 1) / (paeg_pkg::DRAW_SCALE * dq);
    idx = (k > 0) ? k - 1 : 0;
    if (idx >= n) idx = n - 1;
    return 17'(idx);
  endfunction

  task automatic reset_graph();
    p_alpha = 30000; p_beta = 40000; p_gamma = 30000; p_xi = 0;
    p_din = 65536; p_dout = 65536; p_target = 17'(65536);
    num_edges = 1;
    num_nodes = 2;
    src_of_edge[0] = 0; dst_of_edge[0] = 1;
    in_deg[0] = 0; out_deg[0] = 1; in_deg[1] = 1; out_deg[1] = 0;
  endtask

  function automatic graph_result_t grow_graph(input logic rd, input logic [16:0] u,
                                               input logic [16:0] v, input logic [16:0] w,
                                               input logic [16:0] node);
    graph_result_t r;
    longint unsigned t1, t2, t3, t4;
    int unsigned n;
    r = '{default: '0};
    n = num_nodes;
    t1 = p_alpha; t2 = t1 + p_beta; t3 = t2 + p_gamma; t4 = t3 + p_xi;
    if (rd) begin
      if (node < num_nodes) begin
        r.indeg = in_deg[node];
        r.outdeg = out_deg[node];
      end
    end else if (num_edges < stop_count()) begin
      if (u <= t1) begin
        r.to_node = weighted_pick(v, p_din, 1'b1);
        r.from_node = 17'(n);
        in_deg[r.to_node]++;
        out_deg[n] = 1; in_deg[n] = 0;
        num_nodes = n + 1;
        r.scen = paeg_pkg::SCEN_ALPHA;
      end else if (u <= t2) begin
        r.to_node = weighted_pick(v, p_din, 1'b1);
        r.from_node = weighted_pick(w, p_dout, 1'b0);
        in_deg[r.to_node]++;
        out_deg[r.from_node]++;
        r.scen = paeg_pkg::SCEN_BETA;
      end else if (u <= t3) begin
        r.from_node = weighted_pick(w, p_dout, 1'b0);
        r.to_node = 17'(n);
        in_deg[n] = 1; out_deg[n] = 0;
        out_deg[r.from_node]++;
        num_nodes = n + 1;
        r.scen = paeg_pkg::SCEN_GAMMA;
      end else if (u <= t4) begin
        r.from_node = 17'(n);
        r.to_node = 17'(n + 1);
        in_deg[n] = 0; out_deg[n] = 1; in_deg[n+1] = 1; out_deg[n+1] = 0;
        num_nodes = n + 2;
        r.scen = paeg_pkg::SCEN_XI;
      end else begin
        r.from_node = 17'(n);
        r.to_node = 17'(n);
        in_deg[n] = 1; out_deg[n] = 1;
        num_nodes = n + 1;
        r.scen = paeg_pkg::SCEN_LOOP;
      end
      src_of_edge[num_edges] = r.from_node;
      dst_of_edge[num_edges] = r.to_node;
      num_edges++;
    end
    r.edges = 17'(num_edges);
    r.nodes = 18'(num_nodes);
    r.fin = (num_edges >= stop_count());
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", edge_count, -1);
      end else begin
        graph_result_t x;
        x = pending_results.pop_front();
        if (edge_from !== x.from_node) report("edge_from", edge_from, x.from_node);
        if (edge_to !== x.to_node) report("edge_to", edge_to, x.to_node);
        if (scenario !== x.scen) report("scenario", scenario, x.scen);
        if (edge_count !== x.edges) report("edge_count", edge_count, x.edges);
        if (node_count !== x.nodes) report("node_count", node_count, x.nodes);
        if (in_degree !== x.indeg) report("in_degree", in_degree, x.indeg);
        if (out_degree !== x.outdeg) report("out_degree", out_degree, x.outdeg);
        if (finished !== x.fin) report("finished", finished, x.fin);
      end
    end
  end

  bit no_gaps = 0;

  // called at a falling edge; leaves start high so a request can follow at once
  task automatic send_request(input logic rd, input logic [16:0] u, input logic [16:0] v,
                              input logic [16:0] w, input logic [16:0] node);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode <= rd; u_draw <= u; v_draw <= v; w_draw <= w; node_index <= node;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(grow_graph(rd, u, v, w, node));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    start <= 1'b0;
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      paeg_pkg::REG_ALPHA:  p_alpha = val[16:0];
      paeg_pkg::REG_BETA:   p_beta = val[16:0];
      paeg_pkg::REG_GAMMA:  p_gamma = val[16:0];
      paeg_pkg::REG_XI:     p_xi = val[16:0];
      paeg_pkg::REG_DIN:    p_din = val;
      paeg_pkg::REG_DOUT:   p_dout = val;
      paeg_pkg::REG_TARGET: p_target = val[16:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_probs(input int a, input int b, input int g, input int x);
    write_reg(paeg_pkg::REG_ALPHA, 24'(a)); write_reg(paeg_pkg::REG_BETA, 24'(b));
    write_reg(paeg_pkg::REG_GAMMA, 24'(g)); write_reg(paeg_pkg::REG_XI, 24'(x));
  endtask

  function automatic logic [16:0] rand_draw();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd99999;
      2: return 17'($urandom_range(100000, 131071));
      default: return 17'($urandom_range(0, 99999));
    endcase
  endfunction

  task automatic random_mix(input int count);
    repeat (count) begin
      if ($urandom_range(0, 5) == 0)
        send_request(1'b1, 17'($urandom), 17'($urandom), 17'($urandom),
                     ($urandom_range(0, 3) == 0) ? 17'($urandom)
                                                 : 17'($urandom_range(0, num_nodes + 2)));
      else
        send_request(1'b0, rand_draw(), rand_draw(), rand_draw(), 17'($urandom));
    end
  endtask

  task automatic test_directed();
    // every scenario plus draw extremes, first under reset settings, then with xi enabled
    send_request(1'b1, 17'd0, 17'd0, 17'd0, 17'd0);
    send_request(1'b1, 17'd0, 17'd0, 17'd0, 17'd1);
    send_request(1'b0, 17'd0, 17'd0, 17'd0, 17'd0);
    send_request(1'b0, 17'd30000, 17'd99999, 17'd99999, 17'd0);
    send_request(1'b0, 17'd30001, 17'd0, 17'd0, 17'd0);
    send_request(1'b0, 17'd70000, 17'd131071, 17'd131071, 17'd0);
    send_request(1'b0, 17'd70001, 17'd0, 17'd99999, 17'd0);
    send_request(1'b0, 17'd99999, 17'd50000, 17'd0, 17'd0);
    send_request(1'b0, 17'd100000, 17'd0, 17'd0, 17'd0);
    send_request(1'b0, 17'd131071, 17'd131071, 17'd131071, 17'd131071);
    send_request(1'b1, 17'd0, 17'd0, 17'd0, 17'h1FFFF);
    send_request(1'b1, 17'd0, 17'd0, 17'd0, 17'd2);
    drain();
    set_probs(10000, 10000, 10000, 30000);
    send_request(1'b0, 17'd35000, 17'd0, 17'd0, 17'd0);
    send_request(1'b0, 17'd65000, 17'd0, 17'd0, 17'd0);
    send_request(1'b0, 17'd60001, 17'd0, 17'd0, 17'd0);
    drain();
  endtask

  task automatic test_delta_extremes();
    write_reg(paeg_pkg::REG_DIN, 24'd0); write_reg(paeg_pkg::REG_DOUT, 24'hFFFFFF);
    set_probs(30000, 40000, 30000, 0);
    random_mix(150);
    drain();
    write_reg(paeg_pkg::REG_DIN, 24'hFFFFFF); write_reg(paeg_pkg::REG_DOUT, 24'd1);
    random_mix(150);
    drain();
  endtask

  task automatic test_target_stop();
    // finish early, then keep stepping past the end
    write_reg(paeg_pkg::REG_TARGET, 24'(num_edges + 20));
    write_reg(paeg_pkg::REG_DIN, 24'd65536); write_reg(paeg_pkg::REG_DOUT, 24'd32768);
    random_mix(60);
    drain();
    write_reg(paeg_pkg::REG_TARGET, 24'd2);
    random_mix(10);
    drain();
    write_reg(paeg_pkg::REG_TARGET, 24'h1FFFF);
  endtask

  task automatic test_random_settings();
    repeat (5) begin
      set_probs($urandom_range(0, 100000), $urandom_range(0, 100000),
                $urandom_range(0, 50000), $urandom_range(0, 30000));
      write_reg(paeg_pkg::REG_DIN, 24'($urandom_range(1, 24'hFFFFFF)));
      write_reg(paeg_pkg::REG_DOUT, 24'($urandom_range(1, 24'h3FFFF)));
      random_mix(150);
      drain();
    end
    set_probs(0, 0, 0, 0);
    random_mix(30);
    drain();
    set_probs(100000, 100000, 100000, 100000);
    no_gaps = 1;
    random_mix(100);
    no_gaps = 0;
    random_mix(100);
    drain();
  endtask

  initial begin
    reset_graph();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_delta_extremes();
    test_target_stop();
    test_random_settings();
    drain();
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
